[hdl/epcc_pkg.sv]
// ----------------------------------------------------------------------------
// epcc_pkg: shared types and constants for the EVSE pilot charge control
// Holds the pilot state codes, the stream item layouts, the drive state
// and the proximity pilot classification thresholds.
// ----------------------------------------------------------------------------
package epcc_pkg;

  // decoded control pilot level
  typedef enum logic [2:0] {
    PS_A   = 3'd0,  // 12V, no vehicle
    PS_B   = 3'd1,  // 9V, vehicle present
    PS_C   = 3'd2,  // 6V, charge request
    PS_D   = 3'd3,  // 3V, charge with ventilation
    PS_E   = 3'd4,  // 0V
    PS_ERR = 3'd5,  // unknown error
    PS_F   = 3'd6,  // -12V
    PS_INV = 3'd7   // invalid reading
  } pilot_e;

  // input transaction, first field in the high bits
  typedef struct packed {
    logic [7:0]  requested_current;
    logic        lock_feedback;
    logic [11:0] pp_reading;
    pilot_e      pilot_state;
  } item_t;

  // result transaction, first field in the high bits
  typedef struct packed {
    logic       charging;
    logic       connected;
    logic       contactor_on;
    logic       motor_on;
    logic [7:0] pilot_duty;
    logic [5:0] cable_limit;
  } result_t;

  // drive state carried from one transaction to the next
  typedef struct packed {
    logic vehicle_full;
    logic motor_drive;
    logic contactor_drive;
  } drive_t;

  localparam int unsigned ITEM_W   = $bits(item_t);
  localparam int unsigned RESULT_W = $bits(result_t);
  localparam int unsigned S_DATA_W = ((ITEM_W + 7) / 8) * 8;
  localparam int unsigned M_DATA_W = ((RESULT_W + 7) / 8) * 8;

  localparam int unsigned CMAX_W      = 7;
  localparam logic [CMAX_W-1:0] CMAX_RESET = 7'd32;

  // configuration register indexes
  localparam logic REG_CONNECTOR_MAX = 1'b0;

  // proximity pilot windows (inclusive) and the matching cable ratings
  localparam logic [11:0] PP_13A_LO = 12'd2300;
  localparam logic [11:0] PP_13A_HI = 12'd2600;
  localparam logic [11:0] PP_20A_LO = 12'd1500;
  localparam logic [11:0] PP_20A_HI = 12'd1560;
  localparam logic [11:0] PP_32A_LO = 12'd580;
  localparam logic [11:0] PP_32A_HI = 12'd640;
  localparam logic [11:0] PP_63A_LO = 12'd220;
  localparam logic [11:0] PP_63A_HI = 12'd300;

  localparam logic [5:0] CABLE_13A  = 6'd13;
  localparam logic [5:0] CABLE_20A  = 6'd20;
  localparam logic [5:0] CABLE_32A  = 6'd32;
  localparam logic [5:0] CABLE_63A  = 6'd63;
  localparam logic [5:0] CABLE_NONE = 6'd0;

  // duty formula break point and constants, duty in per-mille
  localparam int unsigned LOW_AMPS_MAX = 50;
  localparam int unsigned HIGH_OFFSET  = 640;
  localparam int unsigned PERMILLE     = 1000;

endpackage

[hdl/epcc_core.sv]
// ----------------------------------------------------------------------------
// epcc_core: pilot charge control decision logic
// Classifies the cable, limits the current, looks up the pilot duty and
// applies the pilot state rules to the drive state.
// ----------------------------------------------------------------------------
module epcc_core #(
  parameter int unsigned DUTY_FULL_SCALE = 255
) (
  input  epcc_pkg::item_t               item_i,
  input  epcc_pkg::drive_t              drive_i,
  input  logic [epcc_pkg::CMAX_W-1:0]   cmax_i,
  output epcc_pkg::drive_t              drive_o,
  output epcc_pkg::result_t             result_o
);
  import epcc_pkg::*;

  logic [5:0] cable_limit;
  logic [7:0] amps_req_cmax;
  logic [5:0] amps;
  logic [7:0] duty_tbl [64];
  drive_t     drive_nxt;

  // duty per allowed current, worked out at elaboration
  for (genvar a = 0; a < 64; a++) begin : g_duty
    localparam int unsigned PM = (a <= LOW_AMPS_MAX) ? (a * 100) / 6
                                                     : a * 4 + HIGH_OFFSET;
    localparam int unsigned DV = (a == 0) ? DUTY_FULL_SCALE
                                          : (PM * DUTY_FULL_SCALE) / PERMILLE;
    localparam logic [31:0] DV_BITS = DV;
    assign duty_tbl[a] = DV_BITS[7:0];
  end

  // cable rating from the proximity pilot reading
  always_comb begin
    if (item_i.pp_reading >= PP_13A_LO && item_i.pp_reading <= PP_13A_HI) begin
      cable_limit = CABLE_13A;
    end else if (item_i.pp_reading >= PP_20A_LO && item_i.pp_reading <= PP_20A_HI) begin
      cable_limit = CABLE_20A;
    end else if (item_i.pp_reading >= PP_32A_LO && item_i.pp_reading <= PP_32A_HI) begin
      cable_limit = CABLE_32A;
    end else if (item_i.pp_reading >= PP_63A_LO && item_i.pp_reading <= PP_63A_HI) begin
      cable_limit = CABLE_63A;
    end else begin
      cable_limit = CABLE_NONE;
    end
  end

  // least of request, connector maximum and cable rating
  always_comb begin
    if ({1'b0, cmax_i} < item_i.requested_current) begin
      amps_req_cmax = {1'b0, cmax_i};
    end else begin
      amps_req_cmax = item_i.requested_current;
    end
    if ({2'b00, cable_limit} < amps_req_cmax) begin
      amps = cable_limit;
    end else begin
      amps = amps_req_cmax[5:0];
    end
  end

  // pilot state rules
  always_comb begin
    drive_nxt = drive_i;
    case (item_i.pilot_state)
      PS_A: begin
        drive_nxt = '0;
      end
      PS_B: begin
        if (drive_i.vehicle_full) begin
          drive_nxt.motor_drive     = 1'b0;
          drive_nxt.contactor_drive = 1'b0;
        end else begin
          drive_nxt.motor_drive = 1'b1;
        end
      end
      PS_C: begin
        drive_nxt.motor_drive  = 1'b1;
        drive_nxt.vehicle_full = 1'b1;
        if (!item_i.lock_feedback) begin
          drive_nxt.contactor_drive = 1'b1;
        end
      end
      PS_D: begin
        drive_nxt.vehicle_full = 1'b1;
      end
      PS_E, PS_F: begin
        drive_nxt = drive_i;
      end
      default: begin
        // error and invalid readings drop both drives
        drive_nxt.motor_drive     = 1'b0;
        drive_nxt.contactor_drive = 1'b0;
      end
    endcase
  end

  // result assembly
  always_comb begin
    result_o.cable_limit  = cable_limit;
    result_o.pilot_duty   = duty_tbl[amps];
    result_o.motor_on     = drive_nxt.motor_drive;
    result_o.contactor_on = drive_nxt.contactor_drive;
    result_o.connected    = (item_i.pilot_state == PS_B) || (item_i.pilot_state == PS_C) ||
                            (item_i.pilot_state == PS_D);
    result_o.charging     = (item_i.pilot_state == PS_C) || (item_i.pilot_state == PS_D);
  end

  assign drive_o = drive_nxt;

endmodule

[hdl/evse_pilot_charge_control_top.sv]
// An accepted input transaction passes the input register, then the result register, to the master side.
// Throughput: one transaction per cycle; an input register and a result register
// hold the two stages; while a result waits the input register takes one more
// transaction, then the input side stalls until the result is taken.
// Reset: asynchronous, active low; clears both stage valids, the drive state and
// sets the connector maximum to 32 A.
// ----------------------------------------------------------------------------
// evse_pilot_charge_control_top: EVSE control pilot charge controller
// Stream in pilot samples, stream out cable limit, pilot duty and drive flags.
// ----------------------------------------------------------------------------
module evse_pilot_charge_control_top #(
  parameter int unsigned DUTY_FULL_SCALE = 255
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // input stream
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // tdata: pilot_state[2:0], pp_reading[14:3], lock_feedback[15], requested_current[23:16]
  input  logic [epcc_pkg::S_DATA_W-1:0] s_axis_tdata,
  // result stream
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // tdata: cable_limit[5:0], pilot_duty[13:6], motor_on[14], contactor_on[15],
  //        connected[16], charging[17], zero above
  output logic [epcc_pkg::M_DATA_W-1:0] m_axis_tdata,
  // configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [2:0]                    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import epcc_pkg::*;

  logic              in_valid_q;
  item_t             in_q;
  logic              out_valid_q;
  result_t           out_q;
  drive_t            drive_q;
  drive_t            drive_d;
  result_t           result_d;
  logic [CMAX_W-1:0] cmax_q;
  logic              out_load;
  logic              in_accept;
  logic              cfg_write;

  // stage handshakes
  assign out_load      = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || out_load;
  assign in_accept     = s_axis_tvalid && s_axis_tready;

  // configuration register
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready && (paddr[2] == REG_CONNECTOR_MAX);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmax_q <= CMAX_RESET;
    end else if (cfg_write) begin
      cmax_q <= pwdata[CMAX_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_CONNECTOR_MAX) begin
      prdata[CMAX_W-1:0] = cmax_q;
    end
  end

  // decision logic
  epcc_core #(
    .DUTY_FULL_SCALE(DUTY_FULL_SCALE)
  ) u_core (
    .item_i  (in_q),
    .drive_i (drive_q),
    .cmax_i  (cmax_q),
    .drive_o (drive_d),
    .result_o(result_d)
  );

  // stage valids and drive state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      drive_q     <= '0;
    end else begin
      if (in_accept) begin
        in_valid_q <= 1'b1;
      end else if (out_load) begin
        in_valid_q <= 1'b0;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
        drive_q     <= drive_d;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_q <= item_t'(s_axis_tdata[ITEM_W-1:0]);
    end
    if (out_load) begin
      out_q <= result_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(M_DATA_W - RESULT_W){1'b0}}, out_q};

endmodule

[bench/tb_evse_pilot_charge_control_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_evse_pilot_charge_control_top: stream bench for the EVSE pilot controller
// Drives pilot samples into the input stream and checks every result against
// a cycle-free prediction of cable limit, pilot duty and drive flags. The
// connector maximum is changed over the APB port between phases and read back.
// ----------------------------------------------------------------------------
module tb_evse_pilot_charge_control_top;
  import epcc_pkg::*;

  localparam int unsigned DUTY_FS     = 255;
  localparam int unsigned STALL_LIMIT = 1000;
  localparam logic [2:0]  ADDR_CMAX   = 3'd0;
  localparam logic [2:0]  ADDR_UNUSED = 3'd4;

  logic                clk_i;
  logic                rst_ni;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [S_DATA_W-1:0] s_axis_tdata;
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [M_DATA_W-1:0] m_axis_tdata;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [2:0]          paddr;
  logic [31:0]         pwdata;
  logic [31:0]         prdata;
  logic                pready;

  // predicted controller state and settings
  logic              exp_vehicle_full;
  logic              exp_motor;
  logic              exp_contactor;
  logic [CMAX_W-1:0] exp_cmax;
  result_t           pilot_results_q[$];

  int unsigned errors;
  int unsigned items_sent;
  int unsigned stall_cycles;
  int unsigned rx_hold_cycles;
  bit          tx_idle_on;
  bit          rx_idle_on;

  evse_pilot_charge_control_top #(
    .DUTY_FULL_SCALE(DUTY_FS)
  ) u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // proximity pilot reading to cable rating
  function automatic logic [5:0] cable_rating(input logic [11:0] pp);
    if (pp >= PP_13A_LO && pp <= PP_13A_HI) return CABLE_13A;
    if (pp >= PP_20A_LO && pp <= PP_20A_HI) return CABLE_20A;
    if (pp >= PP_32A_LO && pp <= PP_32A_HI) return CABLE_32A;
    if (pp >= PP_63A_LO && pp <= PP_63A_HI) return CABLE_63A;
    return CABLE_NONE;
  endfunction

  // allowed current to pwm compare value, j1772 per-mille duty
  function automatic logic [7:0] duty_for_amps(input int unsigned amps);
    int unsigned permille;
    if (amps == 0) return 8'(DUTY_FS);
    if (amps <= LOW_AMPS_MAX) permille = amps * 100 / 6;
    else permille = amps * 4 + HIGH_OFFSET;
    return 8'(permille * DUTY_FS / PERMILLE);
  endfunction

  // one pilot step: update drive state, then form the result
  function automatic result_t predict_pilot_step(input item_t it);
    result_t     r;
    logic [5:0]  lim;
    int unsigned amps;
    case (it.pilot_state)
      PS_A: begin
        exp_motor        = 1'b0;
        exp_contactor    = 1'b0;
        exp_vehicle_full = 1'b0;
      end
      PS_B: begin
        if (exp_vehicle_full) begin
          exp_motor     = 1'b0;
          exp_contactor = 1'b0;
        end else begin
          exp_motor = 1'b1;
        end
      end
      PS_C: begin
        exp_motor = 1'b1;
        if (!it.lock_feedback) exp_contactor = 1'b1;
        exp_vehicle_full = 1'b1;
      end
      PS_D: exp_vehicle_full = 1'b1;
      PS_E, PS_F: ;
      default: begin
        exp_motor     = 1'b0;
        exp_contactor = 1'b0;
      end
    endcase
    lim  = cable_rating(it.pp_reading);
    amps = it.requested_current;
    if (exp_cmax < amps) amps = exp_cmax;
    if (lim < amps) amps = lim;
    r.cable_limit  = lim;
    r.pilot_duty   = duty_for_amps(amps);
    r.motor_on     = exp_motor;
    r.contactor_on = exp_contactor;
    r.connected    = (it.pilot_state inside {PS_B, PS_C, PS_D});
    r.charging     = (it.pilot_state inside {PS_C, PS_D});
    return r;
  endfunction

  // prediction at each accepted input transaction and register write
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_vehicle_full = 1'b0;
      exp_motor        = 1'b0;
      exp_contactor    = 1'b0;
      exp_cmax         = CMAX_RESET;
      pilot_results_q.delete();
    end else begin
      if (psel && penable && pwrite && pready && paddr == ADDR_CMAX)
        exp_cmax = pwdata[CMAX_W-1:0];
      if (s_axis_tvalid && s_axis_tready)
        pilot_results_q.push_back(predict_pilot_step(item_t'(s_axis_tdata[ITEM_W-1:0])));
    end
  end

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      errors++;
    end
  endfunction

  // compare each result transaction with the oldest prediction
  always @(posedge clk_i) begin
    result_t want;
    result_t got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = result_t'(m_axis_tdata[RESULT_W-1:0]);
      if (pilot_results_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, got %h", $time, m_axis_tdata);
        errors++;
      end else begin
        want = pilot_results_q.pop_front();
        check_field("cable_limit", want.cable_limit, got.cable_limit);
        check_field("pilot_duty", want.pilot_duty, got.pilot_duty);
        check_field("motor_on", want.motor_on, got.motor_on);
        check_field("contactor_on", want.contactor_on, got.contactor_on);
        check_field("connected", want.connected, got.connected);
        check_field("charging", want.charging, got.charging);
        check_field("tdata padding", 0, m_axis_tdata[M_DATA_W-1:RESULT_W]);
      end
    end
  end

  // result side ready, with random idling and a counted hold-off
  always @(posedge clk_i) begin
    if (rx_hold_cycles > 0) begin
      m_axis_tready  <= 1'b0;
      rx_hold_cycles <= rx_hold_cycles - 1;
    end else begin
      m_axis_tready <= !(rx_idle_on && $urandom_range(99) < 28);
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || psel) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  function automatic item_t make_item(input pilot_e ps, input logic [11:0] pp,
                                      input logic lock, input logic [7:0] req);
    item_t it;
    it.pilot_state       = ps;
    it.pp_reading        = pp;
    it.lock_feedback     = lock;
    it.requested_current = req;
    return it;
  endfunction

  // mostly readings inside a cable window, sometimes anything
  function automatic logic [11:0] pick_pp();
    case ($urandom_range(9))
      0, 1:    return 12'($urandom_range(PP_13A_LO, PP_13A_HI));
      2, 3:    return 12'($urandom_range(PP_20A_LO, PP_20A_HI));
      4, 5:    return 12'($urandom_range(PP_32A_LO, PP_32A_HI));
      6, 7:    return 12'($urandom_range(PP_63A_LO, PP_63A_HI));
      default: return 12'($urandom);
    endcase
  endfunction

  function automatic pilot_e pick_fault();
    case ($urandom_range(3))
      0:       return PS_E;
      1:       return PS_F;
      2:       return PS_ERR;
      default: return PS_INV;
    endcase
  endfunction

  // offer one input transaction, idling first at random
  task automatic send_item(input item_t it);
    while (tx_idle_on && $urandom_range(99) < 28) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= it;
    do @(posedge clk_i); while (!s_axis_tready);
    items_sent++;
  endtask

  // stop offering and let every predicted result come out
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (pilot_results_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // register write, then the bus returns to idle
  task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  // read the connector maximum back and compare
  task automatic check_cmax_readback();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= ADDR_CMAX;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== {{(32-CMAX_W){1'b0}}, exp_cmax}) begin
      $display("%0t: connector_max readback mismatch, expected %0d, got %0d",
               $time, exp_cmax, prdata);
      errors++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_cmax(input logic [CMAX_W-1:0] amps);
    apb_write(ADDR_CMAX, {25'($urandom), amps});
    check_cmax_readback();
  endtask

  // reset value of the register and a first step with it
  task automatic test_reset_state();
    check_cmax_readback();
    send_item(make_item(PS_B, PP_20A_LO, 1'b1, 8'd255));
    wait_drained();
  endtask

  // window edges of the proximity pilot classification
  task automatic test_cable_windows();
    logic [11:0] edges[12];
    edges = '{12'd0, 12'd219, 12'd220, 12'd300, 12'd580, 12'd640, 12'd641,
              12'd1500, 12'd1560, 12'd2300, 12'd2601, 12'd4095};
    set_cmax(7'd80);
    foreach (edges[i]) send_item(make_item(PS_E, edges[i], 1'b1, 8'd255));
    wait_drained();
  endtask

  // every pilot state in a plug-in, charge, full and fault order
  task automatic test_pilot_states();
    send_item(make_item(PS_A, PP_32A_LO, 1'b1, 8'd0));
    send_item(make_item(PS_B, PP_32A_LO, 1'b1, 8'd16));
    send_item(make_item(PS_C, PP_32A_LO, 1'b1, 8'd16));
    send_item(make_item(PS_C, PP_32A_HI, 1'b0, 8'd32));
    send_item(make_item(PS_D, PP_32A_HI, 1'b0, 8'd255));
    send_item(make_item(PS_B, PP_32A_HI, 1'b0, 8'd10));
    send_item(make_item(PS_E, PP_32A_HI, 1'b0, 8'd10));
    send_item(make_item(PS_F, PP_32A_HI, 1'b1, 8'd10));
    send_item(make_item(PS_ERR, PP_32A_HI, 1'b1, 8'd10));
    send_item(make_item(PS_INV, PP_32A_HI, 1'b0, 8'd10));
    send_item(make_item(PS_A, PP_32A_HI, 1'b1, 8'd10));
    wait_drained();
  endtask

  // register extremes, low current without minimum, ignored address
  task automatic test_connector_register();
    set_cmax(7'd0);
    send_item(make_item(PS_B, PP_63A_LO, 1'b1, 8'd255));
    wait_drained();
    // above the stated range: the cable still caps at 63 A
    set_cmax(7'd127);
    send_item(make_item(PS_C, PP_63A_HI, 1'b0, 8'd255));
    wait_drained();
    // below six amperes the low-current formula still applies
    set_cmax(7'd5);
    send_item(make_item(PS_C, PP_13A_HI, 1'b0, 8'd255));
    wait_drained();
    // write to an unmapped register leaves the limit alone
    apb_write(ADDR_UNUSED, 32'h0000_0055);
    check_cmax_readback();
    send_item(make_item(PS_D, PP_13A_LO, 1'b0, 8'd200));
    wait_drained();
    set_cmax(CMAX_RESET);
  endtask

  // receiver holds off while the sender keeps offering
  task automatic test_backpressure();
    tx_idle_on     = 1'b0;
    rx_idle_on     = 1'b0;
    rx_hold_cycles = 80;
    repeat (30) send_item(make_item(pilot_e'(3'($urandom)), pick_pp(), 1'($urandom),
                                    8'($urandom)));
    wait_drained();
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
  endtask

  // one plug-in session with random content, or a noise transaction
  task automatic run_session();
    logic [11:0] pp;
    pp = pick_pp();
    if ($urandom_range(99) < 15) begin
      send_item(make_item(pilot_e'(3'($urandom)), 12'($urandom), 1'($urandom), 8'($urandom)));
      return;
    end
    repeat ($urandom_range(1, 2)) send_item(make_item(PS_A, pp, 1'b1, 8'($urandom)));
    repeat ($urandom_range(1, 3)) send_item(make_item(PS_B, pp, 1'b1, 8'($urandom)));
    repeat ($urandom_range(2, 6))
      send_item(make_item(PS_C, pp, ($urandom_range(3) == 0), 8'($urandom)));
    if ($urandom_range(1))
      repeat ($urandom_range(1, 3)) send_item(make_item(PS_D, pp, 1'($urandom), 8'($urandom)));
    if ($urandom_range(3) == 0)
      send_item(make_item(pick_fault(), pp, 1'($urandom), 8'($urandom)));
    repeat ($urandom_range(1, 3)) send_item(make_item(PS_B, pp, 1'($urandom), 8'($urandom)));
    if ($urandom_range(4) != 0) send_item(make_item(PS_A, pp, 1'($urandom), 8'($urandom)));
  endtask

  // random sessions in phases, a new connector maximum for each
  task automatic test_random_sessions();
    logic [CMAX_W-1:0] limits[5];
    int unsigned       start;
    limits = '{7'd0, 7'd127, 7'd80, 7'($urandom_range(6, 80)), 7'($urandom)};
    start  = items_sent;
    for (int phase = 0; phase < 5; phase++) begin
      wait_drained();
      set_cmax(limits[phase]);
      // one phase runs with no idling on either side
      tx_idle_on = (phase != 2);
      rx_idle_on = (phase != 2);
      while (items_sent < start + (phase + 1) * 150) run_session();
    end
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
  endtask

  initial begin
    rst_ni         = 1'b0;
    s_axis_tvalid  = 1'b0;
    s_axis_tdata   = '0;
    m_axis_tready  = 1'b0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    errors         = 0;
    items_sent     = 0;
    stall_cycles   = 0;
    rx_hold_cycles = 0;
    tx_idle_on     = 1'b1;
    rx_idle_on     = 1'b1;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_state();
    test_cable_windows();
    test_pilot_states();
    test_connector_register();
    test_backpressure();
    test_random_sessions();
    wait_drained();

    if (errors == 0 && pilot_results_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
